FILE: hdl/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared constants for the polyline length accumulator: default widths of
// the coordinate and length fields and the width of the point count.
// ----------------------------------------------------------------------------
package pla_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int LENGTH_BITS_DEF = 40;
	localparam int COUNT_W         = 16;

endpackage

FILE: hdl/polyline_length_accumulator_unit.sv
// ----------------------------------------------------------------------------
// polyline_length_accumulator_unit
// Running Euclidean length of a 3D path, reported on its final point.
// ----------------------------------------------------------------------------
// The first point of a path is only stored. Every later point blocks the
// next request until it has passed through these steps in order: accept
// and form the differences, square them on the shared squaring multiplier
// and sum, load the square root, run the bit-serial square root, and add
// the segment. A final point then moves the result into the output register,
// first waiting, with no request accepted, while the previous result has
// not yet been taken; the next request is accepted while a result waits in
// the output register.
module polyline_length_accumulator_unit #(
	parameter int COORD_BITS  = pla_pkg::COORD_BITS_DEF,
	parameter int LENGTH_BITS = pla_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  pos_z,
	input  logic                          final_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LENGTH_BITS-1:0]        total_length,
	output logic [pla_pkg::COUNT_W-1:0]   points_seen,
	output logic                          too_short
);
	import pla_pkg::*;

	localparam int RAD_W  = 2 * COORD_BITS + 2;
	localparam int ROOT_W = COORD_BITS + 1;
	localparam int SUM_W  = ((LENGTH_BITS > ROOT_W) ? LENGTH_BITS : ROOT_W) + 1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};
	localparam logic [COUNT_W-1:0]     COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUMSQ = 3'd1;
	localparam logic [2:0] ST_ROOT  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;

	logic [2:0]                   state_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [COUNT_W-1:0]           count_q;
	logic [LENGTH_BITS-1:0]       len_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [LENGTH_BITS-1:0]       out_len_q;
	logic [COUNT_W-1:0]           out_cnt_q;
	logic                         out_short_q;

	logic                         accept;
	logic                         sq_start;
	logic                         sq_done;
	logic [RAD_W-1:0]             sum_sq;
	logic                         rt_done;
	logic [ROOT_W-1:0]            seg;
	logic [SUM_W-1:0]             len_add;
	logic [LENGTH_BITS-1:0]       len_next;
	logic                         out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign sq_start = accept && (count_q != '0);
	assign out_free = !out_valid_q || out_ready;

	assign len_add  = SUM_W'(len_q) + SUM_W'(seg);
	assign len_next = (len_add > SUM_W'(LEN_MAX)) ? LEN_MAX : len_add[LENGTH_BITS-1:0];

	pla_sumsq #(
		.COORD_BITS (COORD_BITS)
	) u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.cur_x  (pos_x),
		.cur_y  (pos_y),
		.cur_z  (pos_z),
		.prev_x (prev_x_q),
		.prev_y (prev_y_q),
		.prev_z (prev_z_q),
		.done   (sq_done),
		.sum_sq (sum_sq)
	);

	pla_isqrt #(
		.RAD_W (RAD_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_done),
		.radicand (sum_sq),
		.done     (rt_done),
		.root     (seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			count_q     <= '0;
			len_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_x_q <= pos_x;
						prev_y_q <= pos_y;
						prev_z_q <= pos_z;
						last_q   <= final_point;
						if (count_q != COUNT_MAX)
							count_q <= count_q + COUNT_W'(1);
						if (count_q != '0)
							state_q <= ST_SUMSQ;
						else if (final_point)
							state_q <= ST_FIN;
					end
				end
				ST_SUMSQ: begin
					if (sq_done)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (rt_done) begin
						len_q   <= len_next;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prev_x_q    <= '0;
						prev_y_q    <= '0;
						prev_z_q    <= '0;
						count_q     <= '0;
						len_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_len_q   <= len_q;
			out_cnt_q   <= count_q;
			out_short_q <= (count_q < COUNT_W'(2));
		end
	end

	assign out_valid    = out_valid_q;
	assign total_length = out_len_q;
	assign points_seen  = out_cnt_q;
	assign too_short    = out_short_q;

endmodule

FILE: hdl/pla_sumsq.sv
// ----------------------------------------------------------------------------
// pla_sumsq
// Squared distance between two points: three absolute differences taken on
// start, then squared one per cycle on a single multiplier and summed.
// ----------------------------------------------------------------------------
module pla_sumsq #(
	parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_BITS-1:0]  cur_x,
	input  logic signed [COORD_BITS-1:0]  cur_y,
	input  logic signed [COORD_BITS-1:0]  cur_z,
	input  logic signed [COORD_BITS-1:0]  prev_x,
	input  logic signed [COORD_BITS-1:0]  prev_y,
	input  logic signed [COORD_BITS-1:0]  prev_z,
	output logic                          done,
	output logic [2*COORD_BITS+1:0]       sum_sq
);
	import pla_pkg::*;

	localparam int DW    = COORD_BITS + 1;
	localparam int PW    = 2 * COORD_BITS;
	localparam int RAD_W = 2 * COORD_BITS + 2;
	localparam logic [1:0] LAST_PH = 2'd3;

	logic [COORD_BITS-1:0] d_q [3];
	logic [PW-1:0]         prod_q;
	logic [RAD_W-1:0]      acc_q;
	logic [1:0]            ph_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COORD_BITS-1:0] d_sel;
	logic [COORD_BITS-1:0] adx, ady, adz;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [DW-1:0] d;
		d = DW'(a) - DW'(b);
		if (d[DW-1])
			d = -d;
		return d[COORD_BITS-1:0];
	endfunction

	assign adx   = abs_diff(cur_x, prev_x);
	assign ady   = abs_diff(cur_y, prev_y);
	assign adz   = abs_diff(cur_z, prev_z);
	assign d_sel = (ph_q == 2'd3) ? '0 : d_q[ph_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == LAST_PH) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q[0] <= adx;
			d_q[1] <= ady;
			d_q[2] <= adz;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (ph_q != LAST_PH)
				prod_q <= PW'(d_sel) * PW'(d_sel);
			if (ph_q != 2'd0)
				acc_q <= acc_q + RAD_W'(prod_q);
		end
	end

	assign done   = done_q;
	assign sum_sq = acc_q;

endmodule

FILE: hdl/pla_isqrt.sv
// ----------------------------------------------------------------------------
// pla_isqrt
// Floor integer square root, one result bit per cycle: bring down two
// radicand bits, trial subtract, shift the root.
// ----------------------------------------------------------------------------
module pla_isqrt #(
	parameter int RAD_W = 2 * pla_pkg::COORD_BITS_DEF + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_W-1:0]     radicand,
	output logic                 done,
	output logic [RAD_W/2-1:0]   root
);
	import pla_pkg::*;

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/pla_checker.sv
// ----------------------------------------------------------------------------
// pla_checker
// Port-level checks on the polyline length accumulator, bound to the top.
// ----------------------------------------------------------------------------
module pla_checker #(
	parameter int LENGTH_BITS = pla_pkg::LENGTH_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [LENGTH_BITS-1:0]      total_length,
	input logic [pla_pkg::COUNT_W-1:0] points_seen,
	input logic                        too_short
);
	import pla_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_length)
			&& $stable(points_seen) && $stable(too_short))
		else $error("result changed while stalled");

	a_short_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> too_short == (points_seen < COUNT_W'(2)))
		else $error("too_short disagrees with point count");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_short |-> total_length == '0)
		else $error("short path with nonzero length");

	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> points_seen != '0)
		else $error("result with no points");

	a_no_accept_reset: assert property (@(posedge clk)
		!arst_n |-> !(in_valid && in_ready && out_valid))
		else $error("activity during reset");

endmodule

bind polyline_length_accumulator_unit pla_checker #(
	.LENGTH_BITS (LENGTH_BITS)
) u_pla_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.total_length (total_length),
	.points_seen  (points_seen),
	.too_short    (too_short)
);
